FILE: sv/misaligned_access_v2_decoder_defines.svh
// Assertion macros shared by the misaligned access decoder RTL
`ifndef MISALIGNED_ACCESS_V2_DECODER_DEFINES_SVH
`define MISALIGNED_ACCESS_V2_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MAD_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mad assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define MAD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mad assertion failed");

`endif

FILE: sv/mad_pkg.sv
// Types and constants of the misaligned access decoder
`timescale 1ns / 1ps
package mad_pkg;

  typedef enum logic [1:0] {
    ST_ACCESS       = 2'd0,
    ST_NOT_HANDLED  = 2'd1,
    ST_USER_IGNORED = 2'd2,
    ST_USER_SIGNAL  = 2'd3
  } status_t;

  localparam int unsigned POL_WARN   = 0;
  localparam int unsigned POL_FIXUP  = 1;
  localparam int unsigned POL_SIGNAL = 2;
  localparam logic [2:0]  POLICY_RESET = 3'd2;

  localparam logic [1:0] T32_TAG = 2'b11;

  localparam logic [4:0] OP16_LDH    = 5'b10001;
  localparam logic [4:0] OP16_LDW    = 5'b10010;
  localparam logic [4:0] OP16_LDW_SP = 5'b10011;
  localparam logic [4:0] OP16_STH    = 5'b10101;
  localparam logic [4:0] OP16_STW    = 5'b10110;
  localparam logic [4:0] OP16_STW_SP = 5'b10111;

  localparam logic [5:0] OP32_IMM_LD = 6'b110110;
  localparam logic [5:0] OP32_IMM_ST = 6'b110111;
  localparam logic [5:0] OP32_REG_LD = 6'b110100;
  localparam logic [5:0] OP32_REG_ST = 6'b110101;

  localparam logic [3:0] SUBI_HALF    = 4'd1;
  localparam logic [3:0] SUBI_WORD    = 4'd2;
  localparam logic [3:0] SUBI_DOUBLE  = 4'd3;
  localparam logic [3:0] SUBI_HALF_SX = 4'd5;

  localparam logic [5:0] SUBR_HALF    = 6'd1;
  localparam logic [5:0] SUBR_WORD    = 6'd2;
  localparam logic [5:0] SUBR_HALF_SX = 6'd5;
  localparam logic [5:0] SUBR_MULTI   = 6'd7;

  localparam logic [4:0]  SP_REG     = 5'd14;
  localparam logic [2:0]  PC_STEP16  = 3'd2;
  localparam logic [2:0]  PC_STEP32  = 3'd4;
  localparam logic [31:0] WORD_BYTES = 32'd4;

  typedef struct packed {
    status_t     status;
    logic [31:0] acc_init;
    logic [31:0] mcand;
    logic [4:0]  mul;
    logic        is_store;
    logic        is_half;
    logic        sign_ext;
    logic [4:0]  reg_first;
    logic [4:0]  count;
    logic [2:0]  pc_step;
    logic        warn;
  } job_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] mem_address;
    logic        is_store;
    logic        is_half;
    logic        sign_extend;
    logic [4:0]  reg_index;
    logic [2:0]  pc_step;
    logic        warn;
    logic        last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

endpackage

FILE: sv/mad_ifs.sv
// Channel interfaces of the misaligned access decoder
`timescale 1ns / 1ps
interface mad_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_half;
  logic [15:0] second_half;
  logic [31:0] base_value;
  logic [31:0] index_value;
  logic [31:0] stack_value;
  logic        in_user_mode;

  modport source (output valid, first_half, second_half, base_value, index_value,
                  stack_value, in_user_mode, input ready);
  modport sink (input valid, first_half, second_half, base_value, index_value,
                stack_value, in_user_mode, output ready);
endinterface

interface mad_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] mem_address;
  logic        is_store;
  logic        is_half;
  logic        sign_extend;
  logic [4:0]  reg_index;
  logic [2:0]  pc_step;
  logic        warn;
  logic        last;

  modport source (output valid, status, mem_address, is_store, is_half, sign_extend,
                  reg_index, pc_step, warn, last, input ready);
  modport sink (input valid, status, mem_address, is_store, is_half, sign_extend,
                reg_index, pc_step, warn, last, output ready);
endinterface

interface mad_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] user_policy;

  modport source (output valid, user_policy, input ready);
  modport sink (input valid, user_policy, output ready);
endinterface

FILE: sv/mad_decode.sv
// Instruction decoder: access kind, start address terms, register run and checks
`timescale 1ns / 1ps
module mad_decode
  import mad_pkg::*;
(
  input  logic [15:0] first_half,
  input  logic [15:0] second_half,
  input  logic [31:0] base_value,
  input  logic [31:0] index_value,
  input  logic [31:0] stack_value,
  input  logic        in_user_mode,
  input  logic [2:0]  user_policy,
  output job_t        job
);

  logic        t32;
  logic [31:0] w;
  logic [4:0]  imm5;
  logic [2:0]  rz;
  logic [9:0]  spoff;
  logic [11:0] off;
  logic        ok;
  logic        store;
  logic        half;
  logic        sx;
  logic [4:0]  r0;
  logic [4:0]  cnt;
  logic [31:0] acc;
  logic [31:0] mcand;
  logic [4:0]  mul;
  logic [5:0]  last_reg;
  logic        reg_bad;
  logic        sp_bad;

  assign t32   = (first_half[15:14] == T32_TAG);
  assign w     = {first_half, second_half};
  assign imm5  = first_half[4:0];
  assign rz    = first_half[7:5];
  assign spoff = {first_half[10:8], imm5, 2'b00};
  assign off   = w[11:0];

  always_comb begin
    ok    = 1'b0;
    store = 1'b0;
    half  = 1'b0;
    sx    = 1'b0;
    r0    = '0;
    cnt   = '0;
    acc   = base_value;
    mcand = '0;
    mul   = 5'd1;
    if (!t32) begin
      r0 = {2'b00, rz};
      unique case (first_half[15:11])
        OP16_LDH: begin
          ok = 1'b1; half = 1'b1; mcand = {26'd0, imm5, 1'b0};
        end
        OP16_LDW: begin
          ok = 1'b1; mcand = {25'd0, imm5, 2'b00};
        end
        OP16_LDW_SP: begin
          ok = 1'b1; acc = stack_value; mcand = {22'd0, spoff};
        end
        OP16_STH: begin
          ok = 1'b1; store = 1'b1; half = 1'b1; mcand = {26'd0, imm5, 1'b0};
        end
        OP16_STW: begin
          ok = 1'b1; store = 1'b1; mcand = {25'd0, imm5, 2'b00};
        end
        OP16_STW_SP: begin
          ok = 1'b1; store = 1'b1; acc = stack_value; mcand = {22'd0, spoff};
        end
        default: ok = 1'b0;
      endcase
    end else begin
      unique case (w[31:26]) inside
        OP32_IMM_LD, OP32_IMM_ST: begin
          store = w[26];
          r0    = w[25:21];
          unique case (w[15:12])
            SUBI_HALF: begin
              ok = 1'b1; half = 1'b1; mcand = {19'd0, off, 1'b0};
            end
            SUBI_HALF_SX: begin
              ok = !store; half = 1'b1; sx = 1'b1; mcand = {19'd0, off, 1'b0};
            end
            SUBI_WORD: begin
              ok = 1'b1; mcand = {18'd0, off, 2'b00};
            end
            SUBI_DOUBLE: begin
              ok = 1'b1; cnt = 5'd1; mcand = {18'd0, off, 2'b00};
            end
            default: ok = 1'b0;
          endcase
        end
        OP32_REG_LD, OP32_REG_ST: begin
          store = w[26];
          r0    = w[4:0];
          mcand = index_value;
          mul   = w[9:5];
          unique case (w[15:10])
            SUBR_HALF: begin
              ok = 1'b1; half = 1'b1;
            end
            SUBR_HALF_SX: begin
              ok = !store; half = 1'b1; sx = 1'b1;
            end
            SUBR_WORD: ok = 1'b1;
            SUBR_MULTI: begin
              ok = 1'b1; r0 = w[25:21]; cnt = w[4:0]; mul = '0;
            end
            default: ok = 1'b0;
          endcase
        end
        default: ok = 1'b0;
      endcase
    end
  end

  assign last_reg = {1'b0, r0} + {1'b0, cnt};
  assign reg_bad  = last_reg[5];
  assign sp_bad   = !in_user_mode && !store && ({1'b0, r0} <= {1'b0, SP_REG}) &&
                    (last_reg >= {1'b0, SP_REG});

  always_comb begin
    job.acc_init  = acc;
    job.mcand     = mcand;
    job.mul       = mul;
    job.is_store  = store;
    job.is_half   = half;
    job.sign_ext  = sx;
    job.reg_first = r0;
    job.count     = cnt;
    job.pc_step   = t32 ? PC_STEP32 : PC_STEP16;
    job.warn      = in_user_mode && user_policy[POL_WARN];
    if (in_user_mode && !user_policy[POL_FIXUP]) begin
      job.status = user_policy[POL_SIGNAL] ? ST_USER_SIGNAL : ST_USER_IGNORED;
    end else if (!ok || reg_bad || sp_bad) begin
      job.status = ST_NOT_HANDLED;
    end else begin
      job.status = ST_ACCESS;
    end
    if (job.status != ST_ACCESS) begin
      job.mul   = '0;
      job.count = '0;
    end
  end

endmodule

FILE: sv/misaligned_access_v2_decoder.sv
// Top level of the misaligned access decoder: sequencer, shared adder, result register
//
//   channel    dir   handshake      payload
//   in_chan    in    valid/ready    instruction halfwords, base/index/stack, mode
//   out_chan   out   valid/ready    one fault status, or 1 to 32 accesses, per transaction
//   cfg_chan   in    valid/ready    user_policy
//
// One transaction is taken when idle; a 32-bit shift-add unit then forms the address in
// the CALC state, a multiplier bit at a time, for an immediate offset or register-scaled index;
// a multiple form, a zero scale or a fault skips the CALC state.
// Then one result per cycle while out_chan is free, 1 to 32, the same adder stepping by 4.
// Output stalls hold the sequencer; cfg_chan is always ready.
// rst_n is synchronous; it clears the sequencer, the output valid and sets user_policy to 2.
`timescale 1ns / 1ps
`include "misaligned_access_v2_decoder_defines.svh"
module misaligned_access_v2_decoder
  import mad_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  mad_in_if.sink   in_chan,
  mad_out_if.source out_chan,
  mad_cfg_if.sink  cfg_chan
);

  state_t      state_r, state_nxt;
  logic [2:0]  policy_r;
  job_t        job;
  job_t        job_r;
  logic [31:0] acc_r;
  logic [31:0] mcand_r;
  logic [4:0]  mul_r;
  logic [4:0]  reg_r;
  logic [4:0]  cnt_r;
  res_t        out_r;
  res_t        res;
  logic        out_valid_r;
  logic        accept;
  logic        slot_free;
  logic        emit;
  logic        access;
  logic        out_fault;
  logic [31:0] addend;
  logic [31:0] sum;

  mad_decode u_decode (
    .first_half   (in_chan.first_half),
    .second_half  (in_chan.second_half),
    .base_value   (in_chan.base_value),
    .index_value  (in_chan.index_value),
    .stack_value  (in_chan.stack_value),
    .in_user_mode (in_chan.in_user_mode),
    .user_policy  (policy_r),
    .job          (job)
  );

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign accept    = in_chan.valid && in_chan.ready;
  assign slot_free = !out_valid_r || out_chan.ready;
  assign emit      = (state_r == S_EMIT) && slot_free;

  assign addend = (state_r == S_CALC) ? (mul_r[0] ? mcand_r : '0) : WORD_BYTES;
  assign sum    = acc_r + addend;

  assign access = (job_r.status == ST_ACCESS);
  always_comb begin
    res.status      = job_r.status;
    res.mem_address = access ? acc_r : '0;
    res.is_store    = access && job_r.is_store;
    res.is_half     = access && job_r.is_half;
    res.sign_extend = access && job_r.sign_ext;
    res.reg_index   = access ? reg_r : '0;
    res.pc_step     = (access && cnt_r == '0) ? job_r.pc_step : '0;
    res.warn        = job_r.warn;
    res.last        = (cnt_r == '0);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) begin
        state_nxt = (job.mul != '0) ? S_CALC : S_EMIT;
      end
      S_CALC: if (mul_r[4:1] == '0) begin
        state_nxt = S_EMIT;
      end
      S_EMIT: if (slot_free && cnt_r == '0) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POLICY_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_chan.valid) begin
        policy_r <= cfg_chan.user_policy;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        cnt_r <= job.count;
      end else if (emit && cnt_r != '0) begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r   <= job;
      acc_r   <= job.acc_init;
      mcand_r <= job.mcand;
      mul_r   <= job.mul;
      reg_r   <= job.reg_first;
    end else if (state_r == S_CALC) begin
      acc_r   <= sum;
      mcand_r <= {mcand_r[30:0], 1'b0};
      mul_r   <= {1'b0, mul_r[4:1]};
    end else if (emit && cnt_r != '0) begin
      acc_r <= sum;
      reg_r <= reg_r + 5'd1;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_r.status;
  assign out_chan.mem_address = out_r.mem_address;
  assign out_chan.is_store    = out_r.is_store;
  assign out_chan.is_half     = out_r.is_half;
  assign out_chan.sign_extend = out_r.sign_extend;
  assign out_chan.reg_index   = out_r.reg_index;
  assign out_chan.pc_step     = out_r.pc_step;
  assign out_chan.warn        = out_r.warn;
  assign out_chan.last        = out_r.last;

  assign out_fault = out_valid_r && (out_r.status != ST_ACCESS);

  `MAD_ASSERT_NEXT(a_accept_busy, accept, !in_chan.ready)
  `MAD_ASSERT_NOW(a_fault_single, out_fault, out_r.last && (out_r.pc_step == 3'd0))
  `MAD_ASSERT_NOW(a_step_on_last, out_valid_r && !out_r.last, out_r.pc_step == 3'd0)
  `MAD_ASSERT_NEXT(a_done_idle, emit && (cnt_r == 5'd0), state_r == S_IDLE)
  `MAD_ASSERT_NOW(a_calc_busy, state_r == S_CALC, mul_r != 5'd0)

endmodule

FILE: verif/tb_misaligned_access_v2_decoder.sv
// Testbench of the misaligned access decoder: directed and random traps checked by a predictor
`timescale 1ns / 1ps
module tb_misaligned_access_v2_decoder;
  import mad_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 120;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [3*PHASES-1:0] PHASE_POLICY = {3'd2, 3'd4, 3'd1, 3'd3, 3'd0, 3'd5};

  typedef struct packed {
    logic [15:0] first_half;
    logic [15:0] second_half;
    logic [31:0] base_value;
    logic [31:0] index_value;
    logic [31:0] stack_value;
    logic        in_user_mode;
  } trap_t;

  logic clk;
  logic rst_n;

  mad_in_if  in_chan ();
  mad_out_if out_chan ();
  mad_cfg_if cfg_chan ();

  misaligned_access_v2_decoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  trap_t      pending_traps[$];
  res_t       expected_accesses[$];
  trap_t      offered_trap;
  logic [2:0] policy_setting = POLICY_RESET;
  bit         no_gaps = 1'b0;
  int         issued_traps = 0;
  int         accepted_traps = 0;
  int         received_accesses = 0;
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  int         send_wait = 0;
  int         recv_wait = 0;
  int         hold_left = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void predict_accesses(trap_t t, logic [2:0] policy);
    logic [31:0] code;
    logic [31:0] start;
    logic [31:0] scaled;
    logic [5:0]  op;
    logic [3:0]  imm_sub;
    logic [5:0]  reg_sub;
    logic        user;
    logic        wide;
    logic        store;
    logic        half;
    logic        sext;
    int          count;
    int          first_reg;
    res_t        r;
    user = t.in_user_mode;
    wide = (t.first_half[15:14] == T32_TAG);
    code = {t.first_half, t.second_half};
    r = '0;
    r.warn = user && policy[POL_WARN];
    r.last = 1'b1;
    if (user && !policy[POL_FIXUP]) begin
      r.status = policy[POL_SIGNAL] ? ST_USER_SIGNAL : ST_USER_IGNORED;
      expected_accesses.push_back(r);
      return;
    end
    start = '0;
    store = 1'b0;
    half = 1'b0;
    sext = 1'b0;
    count = 1;
    if (!wide) begin
      first_reg = t.first_half[7:5];
      case (t.first_half[15:11])
        OP16_LDH: begin
          start = t.base_value + {26'd0, t.first_half[4:0], 1'b0};
          half = 1'b1;
        end
        OP16_LDW: start = t.base_value + {25'd0, t.first_half[4:0], 2'b00};
        OP16_LDW_SP: start = t.stack_value + {22'd0, t.first_half[10:8], t.first_half[4:0], 2'b00};
        OP16_STH: begin
          start = t.base_value + {26'd0, t.first_half[4:0], 1'b0};
          half = 1'b1;
          store = 1'b1;
        end
        OP16_STW: begin
          start = t.base_value + {25'd0, t.first_half[4:0], 2'b00};
          store = 1'b1;
        end
        OP16_STW_SP: begin
          start = t.stack_value + {22'd0, t.first_half[10:8], t.first_half[4:0], 2'b00};
          store = 1'b1;
        end
        default: count = 0;
      endcase
    end else begin
      op = code[31:26];
      first_reg = code[25:21];
      imm_sub = code[15:12];
      reg_sub = code[15:10];
      store = (op == OP32_IMM_ST) || (op == OP32_REG_ST);
      scaled = t.base_value + t.index_value * {27'd0, code[9:5]};
      if (op == OP32_IMM_LD || op == OP32_IMM_ST) begin
        if (imm_sub == SUBI_HALF) begin
          start = t.base_value + {19'd0, code[11:0], 1'b0};
          half = 1'b1;
        end else if (imm_sub == SUBI_HALF_SX && !store) begin
          start = t.base_value + {19'd0, code[11:0], 1'b0};
          half = 1'b1;
          sext = 1'b1;
        end else if (imm_sub == SUBI_WORD) begin
          start = t.base_value + {18'd0, code[11:0], 2'b00};
        end else if (imm_sub == SUBI_DOUBLE) begin
          start = t.base_value + {18'd0, code[11:0], 2'b00};
          count = 2;
        end else begin
          count = 0;
        end
      end else if (op == OP32_REG_LD || op == OP32_REG_ST) begin
        if (reg_sub == SUBR_HALF) begin
          start = scaled;
          half = 1'b1;
          first_reg = code[4:0];
        end else if (reg_sub == SUBR_HALF_SX && !store) begin
          start = scaled;
          half = 1'b1;
          sext = 1'b1;
          first_reg = code[4:0];
        end else if (reg_sub == SUBR_WORD) begin
          start = scaled;
          first_reg = code[4:0];
        end else if (reg_sub == SUBR_MULTI) begin
          start = t.base_value;
          count = code[4:0] + 1;
        end else begin
          count = 0;
        end
      end else begin
        count = 0;
      end
    end
    // drop the whole list if any target is out of range or a kernel load into sp
    for (int k = 0; k < count; k++) begin
      if (first_reg + k > 31 || (!user && !store && first_reg + k == SP_REG))
        count = 0;
    end
    if (count == 0) begin
      r.status = ST_NOT_HANDLED;
      expected_accesses.push_back(r);
      return;
    end
    for (int k = 0; k < count; k++) begin
      r.status = ST_ACCESS;
      r.mem_address = start + WORD_BYTES * 32'(k);
      r.is_store = store;
      r.is_half = half;
      r.sign_extend = sext;
      r.reg_index = 5'(first_reg + k);
      r.last = (k == count - 1);
      r.pc_step = r.last ? (wide ? PC_STEP32 : PC_STEP16) : 3'd0;
      expected_accesses.push_back(r);
    end
  endfunction

  function automatic trap_t make_trap(logic [31:0] code, logic [31:0] base,
                                      logic [31:0] index, logic [31:0] stack, int user);
    trap_t t;
    t.first_half = code[31:16];
    t.second_half = code[15:0];
    t.base_value = base;
    t.index_value = index;
    t.stack_value = stack;
    t.in_user_mode = 1'(user);
    return t;
  endfunction

  function automatic trap_t random_trap();
    trap_t      t;
    logic [31:0] code;
    logic [5:0]  op;
    logic [4:0]  op16;
    logic [4:0]  first_reg;
    logic [4:0]  run;
    logic [3:0]  imm_sub;
    logic [5:0]  reg_sub;
    int          kind;
    code = $urandom;
    kind = $urandom_range(0, 99);
    t.base_value = $urandom;
    t.index_value = $urandom;
    t.stack_value = $urandom;
    t.in_user_mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: t.base_value = 32'hFFFF_FFFC | $urandom_range(0, 3);
      1: t.base_value = $urandom_range(0, 3);
      2: t.index_value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      3: t.stack_value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: ;
    endcase
    if (kind < 30) begin
      case ($urandom_range(0, 5))
        0: op16 = OP16_LDH;
        1: op16 = OP16_LDW;
        2: op16 = OP16_LDW_SP;
        3: op16 = OP16_STH;
        4: op16 = OP16_STW;
        default: op16 = OP16_STW_SP;
      endcase
      code = {op16, code[26:0]};
    end else if (kind < 50) begin
      op = $urandom_range(0, 1) ? OP32_IMM_ST : OP32_IMM_LD;
      case ($urandom_range(0, 3))
        0: imm_sub = SUBI_HALF;
        1: imm_sub = SUBI_WORD;
        2: imm_sub = SUBI_DOUBLE;
        default: imm_sub = SUBI_HALF_SX;
      endcase
      code = {op, code[25:16], imm_sub, code[11:0]};
    end else if (kind < 65) begin
      op = $urandom_range(0, 1) ? OP32_REG_ST : OP32_REG_LD;
      case ($urandom_range(0, 2))
        0: reg_sub = SUBR_HALF;
        1: reg_sub = SUBR_WORD;
        default: reg_sub = SUBR_HALF_SX;
      endcase
      code = {op, code[25:16], reg_sub, code[9:0]};
    end else if (kind < 85) begin
      op = $urandom_range(0, 1) ? OP32_REG_ST : OP32_REG_LD;
      run = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
      first_reg = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
                  5'($urandom_range(0, 31 - run));
      code = {op, first_reg, code[20:16], SUBR_MULTI, code[9:5], run};
    end
    t.first_half = code[31:16];
    t.second_half = code[15:0];
    if (t.first_half[15:14] == T32_TAG && $urandom_range(0, 9) == 0)
      t.first_half[9:5] = SP_REG;
    return t;
  endfunction

  task automatic queue_trap(trap_t t);
    pending_traps.push_back(t);
    issued_traps++;
  endtask

  task automatic drain();
    while (accepted_traps != issued_traps || expected_accesses.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_policy(logic [2:0] value);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.user_policy <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    policy_setting = value;
    cfg_chan.valid <= 1'b0;
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_access();
    res_t want;
    if (expected_accesses.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual status %0d address %0h reg %0d",
               $time, out_chan.status, out_chan.mem_address, out_chan.reg_index);
      mismatch_count++;
    end else begin
      want = expected_accesses.pop_front();
      compare_field("status", want.status, out_chan.status);
      compare_field("mem_address", want.mem_address, out_chan.mem_address);
      compare_field("is_store", want.is_store, out_chan.is_store);
      compare_field("is_half", want.is_half, out_chan.is_half);
      compare_field("sign_extend", want.sign_extend, out_chan.sign_extend);
      compare_field("reg_index", want.reg_index, out_chan.reg_index);
      compare_field("pc_step", want.pc_step, out_chan.pc_step);
      compare_field("warn", want.warn, out_chan.warn);
      compare_field("last", want.last, out_chan.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_accesses(offered_trap, policy_setting);
        accepted_traps++;
        send_wait = no_gaps ? 0 : $urandom_range(0, 14);
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_chan.valid <= 1'b0;
        end else if (pending_traps.size() > 0) begin
          offered_trap = pending_traps.pop_front();
          in_chan.valid <= 1'b1;
          in_chan.first_half <= offered_trap.first_half;
          in_chan.second_half <= offered_trap.second_half;
          in_chan.base_value <= offered_trap.base_value;
          in_chan.index_value <= offered_trap.index_value;
          in_chan.stack_value <= offered_trap.stack_value;
          in_chan.in_user_mode <= offered_trap.in_user_mode;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        check_access();
        received_accesses++;
        recv_wait = no_gaps ? 0 : $urandom_range(0, 14);
        // hold off long enough for the input side to back up
        if (received_accesses == HOLD_AT)
          hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.first_half = '0;
    in_chan.second_half = '0;
    in_chan.base_value = '0;
    in_chan.index_value = '0;
    in_chan.stack_value = '0;
    in_chan.in_user_mode = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.user_policy = POLICY_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    queue_trap(make_trap({OP16_LDH, 3'd0, 3'd7, 5'd31, 16'hFFFF}, 32'hFFFF_FFFE, 0, 0, 0));
    queue_trap(make_trap({OP16_LDW_SP, 3'd7, 3'd1, 5'd31, 16'h0000}, 0, 0, 32'hFFFF_FFFF, 0));
    queue_trap(make_trap({OP16_LDW, 11'h000, 16'h5A5A}, 0, 32'hFFFF_FFFF, 0, 0));
    queue_trap(make_trap({OP16_STH, 3'd5, 3'd3, 5'd17, 16'h0000}, 32'h1234_5679, 0, 0, 0));
    queue_trap(make_trap({OP16_STW, 3'd2, 3'd6, 5'd9, 16'hA5A5}, 32'hFFFF_FFF0, 0, 0, 0));
    queue_trap(make_trap({OP16_STW_SP, 3'd4, 3'd2, 5'd3, 16'h0000}, 0, 0, 32'h8000_0001, 0));
    queue_trap(make_trap(32'h0000_0000, 0, 0, 0, 0));
    queue_trap(make_trap(32'hA7FF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
    queue_trap(make_trap({OP32_IMM_LD, 5'd3, 5'd31, SUBI_HALF, 12'hFFF}, 32'hFFFF_FFFF, 0, 0, 0));
    queue_trap(make_trap({OP32_IMM_LD, 5'd31, 5'd0, SUBI_HALF_SX, 12'h001}, 32'h10, 0, 0, 0));
    queue_trap(make_trap({OP32_IMM_ST, 5'd4, 5'd0, SUBI_HALF_SX, 12'h010}, 32'h20, 0, 0, 0));
    queue_trap(make_trap({OP32_IMM_ST, 5'd14, 5'd0, SUBI_WORD, 12'h800}, 32'h3, 0, 0, 0));
    queue_trap(make_trap({OP32_IMM_LD, 5'd30, 5'd0, SUBI_DOUBLE, 12'hFFF}, 32'hFFFF_FFFF, 0, 0, 0));
    queue_trap(make_trap({OP32_IMM_ST, 5'd31, 5'd0, SUBI_DOUBLE, 12'h000}, 32'h40, 0, 0, 0));
    queue_trap(make_trap({OP32_IMM_LD, 5'd13, 5'd0, SUBI_DOUBLE, 12'h004}, 32'h50, 0, 0, 0));
    queue_trap(make_trap({OP32_IMM_LD, 5'd14, 5'd0, SUBI_WORD, 12'h002}, 32'h60, 0, 0, 0));
    queue_trap(make_trap({OP32_IMM_LD, 5'd14, 5'd0, SUBI_WORD, 12'h002}, 32'h60, 0, 0, 1));
    queue_trap(make_trap({OP32_REG_LD, 5'd0, 5'd0, SUBR_HALF, 5'd31, 5'd7},
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    queue_trap(make_trap({OP32_REG_LD, 5'd0, 5'd0, SUBR_HALF_SX, 5'd1, 5'd31},
                         32'h7FFF_FFFF, 32'h1, 0, 0));
    queue_trap(make_trap({OP32_REG_ST, 5'd0, 5'd31, SUBR_WORD, 5'd0, 5'd14},
                         32'h100, 32'h55, 0, 0));
    queue_trap(make_trap({OP32_REG_ST, 5'd0, 5'd0, SUBR_MULTI, 5'd0, 5'd31},
                         32'hFFFF_FFF8, 0, 0, 0));
    queue_trap(make_trap({OP32_REG_LD, 5'd0, 5'd0, SUBR_MULTI, 5'd0, 5'd31}, 32'h1002, 0, 0, 1));
    queue_trap(make_trap({OP32_REG_ST, 5'd1, 5'd0, SUBR_MULTI, 5'd0, 5'd31}, 32'h2000, 0, 0, 0));
    queue_trap(make_trap({OP32_REG_LD, 5'd10, 5'd0, SUBR_MULTI, 5'd0, 5'd5}, 32'h3000, 0, 0, 0));
    queue_trap(make_trap({OP32_REG_ST, 5'd2, 5'd0, SUBR_HALF_SX, 5'd3, 5'd4}, 32'h4000, 1, 0, 0));
    queue_trap(make_trap(32'hC000_0000, 0, 0, 0, 0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_policy(PHASE_POLICY[3*p +: 3]);
      no_gaps = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++)
        queue_trap(random_trap());
      drain();
    end

    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/mad_pkg.sv
sv/mad_ifs.sv
sv/mad_decode.sv
sv/misaligned_access_v2_decoder.sv
verif/tb_misaligned_access_v2_decoder.sv
